// ===== rtl/bcd_pkg.sv =====
// ----------------------------------------------------------------------------
// bcd_pkg
// Types and constants shared by the block cache directory.
// ----------------------------------------------------------------------------
package bcd_pkg;

   localparam logic [1:0] OP_GET   = 2'd0;
   localparam logic [1:0] OP_PIN   = 2'd1;
   localparam logic [1:0] OP_UNPIN = 2'd2;
   localparam logic [1:0] OP_RSVD  = 2'd3;

   localparam int         PIN_W   = 4;
   localparam logic [3:0] PIN_MAX = 4'd15;

   localparam int DEV_W = 8;
   localparam int BLK_W = 32;
   localparam int TAG_W = DEV_W + BLK_W;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [3:0]  dev_major;
      logic [3:0]  dev_minor;
      logic [31:0] block_number;
      logic [5:0]  entry_index;
   } req_type;

   typedef struct packed {
      logic       hit;
      logic [5:0] entry;
      logic       fill_needed;
      logic       replaced_valid;
      logic       no_free_entry;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LK_RD,
      ST_LK_CMP,
      ST_ALLOC,
      ST_POS_RD,
      ST_POS_CMP,
      ST_SWAP_RD,
      ST_SWAP_WR,
      ST_SWAP_FIN,
      ST_EV_ORD,
      ST_EV_PIN,
      ST_EV_CHK,
      ST_SH_RD,
      ST_SH_WR,
      ST_EV_FIN,
      ST_PIN_RD,
      ST_PIN_WR,
      ST_RESP
   } state_type;

endpackage

// ===== rtl/bcd_ram.sv =====
// ----------------------------------------------------------------------------
// bcd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/block_cache_directory.sv =====
// ----------------------------------------------------------------------------
// block_cache_directory
// Tag directory of a block buffer cache with transposition replacement.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req_ (valid/stall), one result per request leaves
// on rsp_. A get looks the device and block up among the entries in use; a
// hit swaps the entry with its successor in the replacement order, a miss
// takes the next unused entry, or evicts the first unpinned entry from the
// head of the order and moves it to the tail. Pin and unpin adjust a
// saturating per-entry count.
// Sequencing: one request at a time. The lookup reads the tag RAM entry by
// entry over the entries in use; a hit then walks the order RAM position by
// position up to the hit, then swaps unless the hit is at the tail. An
// eviction walks order and pin RAMs position by position up to the victim,
// then shifts the rest of the order. Pin and unpin read, then write the pin
// RAM; a filling miss with free entries allocates after the lookup.
// Reset: a clearing pass over all ENTRIES zeroes the pin counts; req_stall
// stays high meanwhile. The result is held in an output register; while
// rsp_stall is high it holds, and the next request is still taken and worked
// on until its own result is ready.
// ----------------------------------------------------------------------------
module block_cache_directory #(
   parameter int ENTRIES     = 64,
   parameter int MAJOR_COUNT = 16,
   parameter int MINOR_COUNT = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  bcd_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output bcd_pkg::rsp_type rsp_data
);
   import bcd_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [CNT_W-1:0] alloc_ff, alloc_in;
   logic [IDX_W-1:0] ent_ff, ent_in;
   req_type          req_ff, req_in;
   rsp_type          res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             tag_we;
   logic [IDX_W-1:0] tag_waddr;
   logic [TAG_W-1:0] tag_wdata, tag_rd;
   logic             ord_we;
   logic [IDX_W-1:0] ord_waddr, ord_wdata, ord_raddr, ord_rd;
   logic             pin_we;
   logic [IDX_W-1:0] pin_waddr, pin_raddr;
   logic [PIN_W-1:0] pin_wdata, pin_rd;

   logic             req_acc, slot_free, dev_bad, idx_ok, tag_match;
   logic             scan_last, shift_last, clr_last, alloc_full;
   logic [IDX_W-1:0] scan_idx, alloc_idx;
   logic [CNT_W-1:0] scan_inc;

   bcd_ram #(.WIDTH(TAG_W), .DEPTH(ENTRIES)) u_tag_ram (
      .clock  (clock),
      .wr_en  (tag_we),
      .wr_addr(tag_waddr),
      .wr_data(tag_wdata),
      .rd_addr(scan_idx),
      .rd_data(tag_rd)
   );

   bcd_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_order_ram (
      .clock  (clock),
      .wr_en  (ord_we),
      .wr_addr(ord_waddr),
      .wr_data(ord_wdata),
      .rd_addr(ord_raddr),
      .rd_data(ord_rd)
   );

   bcd_ram #(.WIDTH(PIN_W), .DEPTH(ENTRIES)) u_pin_ram (
      .clock  (clock),
      .wr_en  (pin_we),
      .wr_addr(pin_waddr),
      .wr_data(pin_wdata),
      .rd_addr(pin_raddr),
      .rd_data(pin_rd)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_acc    = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign scan_idx   = scan_ff[IDX_W-1:0];
   assign alloc_idx  = alloc_ff[IDX_W-1:0];
   assign scan_inc   = scan_ff + CNT_W'(1);
   assign scan_last  = (scan_inc == alloc_ff);
   assign shift_last = ((scan_ff + CNT_W'(2)) == alloc_ff);
   assign clr_last   = (scan_ff == CNT_W'(ENTRIES - 1));
   assign alloc_full = (alloc_ff == CNT_W'(ENTRIES));
   assign dev_bad    = (32'(req_data.dev_major) >= MAJOR_COUNT) ||
                       (32'(req_data.dev_minor) >= MINOR_COUNT);
   assign idx_ok     = (32'(req_data.entry_index) < ENTRIES);
   assign tag_match  = (tag_rd == {req_ff.dev_major, req_ff.dev_minor, req_ff.block_number});

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:    if (clr_last) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_acc) begin
               if (req_data.opcode == OP_GET) begin
                  if (dev_bad)                  state_in = ST_RESP;
                  else if (alloc_ff == '0)      state_in = ST_ALLOC;
                  else                          state_in = ST_LK_RD;
               end else if ((req_data.opcode == OP_PIN || req_data.opcode == OP_UNPIN)
                            && idx_ok) begin
                  state_in = ST_PIN_RD;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_LK_RD:    state_in = ST_LK_CMP;
         ST_LK_CMP: begin
            if (tag_match)        state_in = ST_POS_RD;
            else if (!scan_last)  state_in = ST_LK_RD;
            else if (!alloc_full) state_in = ST_ALLOC;
            else                  state_in = ST_EV_ORD;
         end
         ST_ALLOC:    state_in = ST_RESP;
         ST_POS_RD:   state_in = ST_POS_CMP;
         ST_POS_CMP: begin
            if (ord_rd == ent_ff) state_in = scan_last ? ST_RESP : ST_SWAP_RD;
            else                  state_in = ST_POS_RD;
         end
         ST_SWAP_RD:  state_in = ST_SWAP_WR;
         ST_SWAP_WR:  state_in = ST_SWAP_FIN;
         ST_SWAP_FIN: state_in = ST_RESP;
         ST_EV_ORD:   state_in = ST_EV_PIN;
         ST_EV_PIN:   state_in = ST_EV_CHK;
         ST_EV_CHK: begin
            if (pin_rd == '0)    state_in = scan_last ? ST_EV_FIN : ST_SH_RD;
            else if (scan_last)  state_in = ST_RESP;
            else                 state_in = ST_EV_ORD;
         end
         ST_SH_RD:    state_in = ST_SH_WR;
         ST_SH_WR:    state_in = shift_last ? ST_EV_FIN : ST_SH_RD;
         ST_EV_FIN:   state_in = ST_RESP;
         ST_PIN_RD:   state_in = ST_PIN_WR;
         ST_PIN_WR:   state_in = ST_RESP;
         ST_RESP:     if (slot_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      scan_in      = scan_ff;
      alloc_in     = alloc_ff;
      ent_in       = ent_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      tag_we       = 1'b0;
      tag_waddr    = ent_ff;
      tag_wdata    = {req_ff.dev_major, req_ff.dev_minor, req_ff.block_number};
      ord_we       = 1'b0;
      ord_waddr    = scan_idx;
      ord_wdata    = ent_ff;
      ord_raddr    = scan_idx;
      pin_we       = 1'b0;
      pin_waddr    = scan_idx;
      pin_wdata    = '0;
      pin_raddr    = IDX_W'(req_ff.entry_index);

      unique case (state_ff)
         ST_CLEAR: begin
            pin_we  = 1'b1;
            scan_in = scan_inc;
         end
         ST_IDLE: begin
            scan_in = '0;
            if (req_acc) begin
               req_in = req_data;
               res_in = '0;
               if (req_data.opcode == OP_GET) begin
                  res_in.no_free_entry = dev_bad;
               end else if (req_data.opcode == OP_PIN || req_data.opcode == OP_UNPIN) begin
                  res_in.entry = req_data.entry_index;
               end
            end
         end
         ST_LK_CMP: begin
            if (tag_match) begin
               ent_in  = scan_idx;
               scan_in = '0;
            end else if (!scan_last) begin
               scan_in = scan_inc;
            end else begin
               scan_in = '0;
            end
         end
         ST_ALLOC: begin
            tag_we    = 1'b1;
            tag_waddr = alloc_idx;
            ord_we    = 1'b1;
            ord_waddr = alloc_idx;
            ord_wdata = alloc_idx;
            alloc_in  = alloc_ff + CNT_W'(1);
            res_in.entry       = 6'(alloc_idx);
            res_in.fill_needed = 1'b1;
         end
         ST_POS_CMP: begin
            if (ord_rd == ent_ff) begin
               res_in.hit   = 1'b1;
               res_in.entry = 6'(ent_ff);
            end
            if (!(ord_rd == ent_ff && scan_last)) scan_in = scan_inc;
         end
         ST_SWAP_WR: begin
            // successor moves into the hit position
            ord_we    = 1'b1;
            ord_waddr = scan_idx - IDX_W'(1);
            ord_wdata = ord_rd;
         end
         ST_SWAP_FIN: begin
            ord_we = 1'b1;
         end
         ST_EV_PIN: begin
            ent_in    = ord_rd;
            pin_raddr = ord_rd;
         end
         ST_EV_CHK: begin
            if (pin_rd != '0) begin
               if (scan_last) res_in.no_free_entry = 1'b1;
               else           scan_in = scan_inc;
            end
         end
         ST_SH_RD: begin
            ord_raddr = scan_inc[IDX_W-1:0];
         end
         ST_SH_WR: begin
            ord_we    = 1'b1;
            ord_wdata = ord_rd;
            scan_in   = scan_inc;
         end
         ST_EV_FIN: begin
            tag_we    = 1'b1;
            ord_we    = 1'b1;
            ord_waddr = alloc_idx - IDX_W'(1);
            res_in.entry          = 6'(ent_ff);
            res_in.fill_needed    = 1'b1;
            res_in.replaced_valid = 1'b1;
         end
         ST_PIN_WR: begin
            pin_we    = 1'b1;
            pin_waddr = IDX_W'(req_ff.entry_index);
            if (req_ff.opcode == OP_PIN) begin
               pin_wdata = (pin_rd == PIN_MAX) ? pin_rd : pin_rd + PIN_W'(1);
            end else begin
               pin_wdata = (pin_rd == '0) ? pin_rd : pin_rd - PIN_W'(1);
            end
         end
         ST_RESP: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         scan_ff      <= '0;
         alloc_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         alloc_ff     <= alloc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff      <= ent_in;
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== rtl/bcd_checker.sv =====
// ----------------------------------------------------------------------------
// bcd_checker
// Port-level checks on the block cache directory.
// ----------------------------------------------------------------------------
module bcd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input bcd_pkg::rsp_type rsp_data
);
   import bcd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_hit_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.hit && rsp_data.fill_needed))
      else $error("hit and fill both set");

   a_nofree: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.no_free_entry |->
         !rsp_data.hit && !rsp_data.fill_needed && rsp_data.entry == 6'd0)
      else $error("failed get carries an entry");

   a_repl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.replaced_valid |-> rsp_data.fill_needed)
      else $error("eviction without fill");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_stall)
      else $error("not quiet after reset");

endmodule

bind block_cache_directory bcd_checker u_bcd_checker (
   .clock    (clock),
   .reset    (reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);

// ===== test/bcd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_scoreboard
// Watches both channels of the block cache directory, keeps its own copy of
// the tags, pin counts and replacement order, and compares every result.
// ----------------------------------------------------------------------------
module bcd_scoreboard
   import bcd_pkg::*;
#(
   parameter int ENTRIES = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending
);

   logic             valid_q  [ENTRIES];
   logic [7:0]       dev_q    [ENTRIES];
   logic [31:0]      blk_q    [ENTRIES];
   logic [3:0]       pins_q   [ENTRIES];
   int               order_q  [ENTRIES];
   int               in_use;
   rsp_type          expected_rsp[$];

   function automatic rsp_type answer_get(logic [3:0] mj, logic [3:0] mn, logic [31:0] blk);
      rsp_type r;
      logic [7:0] dev;
      int e;
      r = '0;
      dev = {mj, mn};
      for (int i = 0; i < in_use; i++) begin
         e = order_q[i];
         if (valid_q[e] && dev_q[e] == dev && blk_q[e] == blk) begin
            if (i + 1 < in_use) begin
               order_q[i] = order_q[i + 1];
               order_q[i + 1] = e;
            end
            r.hit = 1'b1;
            r.entry = e[5:0];
            return r;
         end
      end
      if (in_use < ENTRIES) begin
         e = in_use;
         order_q[in_use] = e;
         in_use++;
         valid_q[e] = 1'b1; dev_q[e] = dev; blk_q[e] = blk;
         r.entry = e[5:0];
         r.fill_needed = 1'b1;
         return r;
      end
      for (int i = 0; i < in_use; i++) begin
         e = order_q[i];
         if (pins_q[e] == 4'd0) begin
            r.replaced_valid = valid_q[e];
            for (int k = i; k + 1 < in_use; k++) order_q[k] = order_q[k + 1];
            order_q[in_use - 1] = e;
            valid_q[e] = 1'b1; dev_q[e] = dev; blk_q[e] = blk;
            r.entry = e[5:0];
            r.fill_needed = 1'b1;
            return r;
         end
      end
      r.no_free_entry = 1'b1;
      return r;
   endfunction

   function automatic rsp_type answer_request(req_type q);
      rsp_type r;
      r = '0;
      case (q.opcode) inside
         OP_GET: r = answer_get(q.dev_major, q.dev_minor, q.block_number);
         OP_PIN, OP_UNPIN: begin
            if (q.opcode == OP_PIN && pins_q[q.entry_index] != PIN_MAX)
               pins_q[q.entry_index]++;
            if (q.opcode == OP_UNPIN && pins_q[q.entry_index] != 4'd0)
               pins_q[q.entry_index]--;
            r.entry = q.entry_index;
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type ex;
      if (reset) begin
         fail_count <= 0;
         in_use = 0;
         for (int i = 0; i < ENTRIES; i++) begin
            valid_q[i] = 1'b0; dev_q[i] = '0; blk_q[i] = '0;
            pins_q[i] = '0; order_q[i] = 0;
         end
         expected_rsp.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $error("result with no request waiting: %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               ex = expected_rsp.pop_front();
               if (ex != rsp_data) begin
                  if (ex.hit != rsp_data.hit)
                     $error("hit: expected %0d actual %0d", ex.hit, rsp_data.hit);
                  if (ex.entry != rsp_data.entry)
                     $error("entry: expected %0d actual %0d", ex.entry, rsp_data.entry);
                  if (ex.fill_needed != rsp_data.fill_needed)
                     $error("fill_needed: expected %0d actual %0d",
                            ex.fill_needed, rsp_data.fill_needed);
                  if (ex.replaced_valid != rsp_data.replaced_valid)
                     $error("replaced_valid: expected %0d actual %0d",
                            ex.replaced_valid, rsp_data.replaced_valid);
                  if (ex.no_free_entry != rsp_data.no_free_entry)
                     $error("no_free_entry: expected %0d actual %0d",
                            ex.no_free_entry, rsp_data.no_free_entry);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_rsp.push_back(answer_request(req_data));
      end
      pending = expected_rsp.size();
   end

endmodule

// ===== test/tb_block_cache_directory.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_block_cache_directory
// Drives directed and random get, pin and unpin requests into the block
// cache directory with random gaps and stalls; the checker judges results.
// ----------------------------------------------------------------------------
module tb_block_cache_directory;
   import bcd_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   bit      quiet_phase = 1'b0;
   bit      hold_rsp = 1'b0;
   int      idle_cycles = 0;
   logic [31:0] hot_blocks[8];

   always #2 clock = ~clock;

   block_cache_directory dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   bcd_scoreboard #(.ENTRIES(64)) chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending)
   );

   // receiver stalls; during a long hold-off rsp_stall is held high
   always @(negedge clock) begin
      if (hold_rsp) rsp_stall <= 1'b1;
      else rsp_stall <= !quiet_phase && ($urandom_range(99) < 8);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // valid stays high after acceptance; a gap in the next call, or the caller, drops it
   task automatic send_request(req_type q);
      while (!quiet_phase && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic req_type make_get(logic [3:0] mj, logic [3:0] mn, logic [31:0] blk);
      req_type q;
      q = '0;
      q.opcode = OP_GET; q.dev_major = mj; q.dev_minor = mn; q.block_number = blk;
      q.entry_index = 6'($urandom);
      return q;
   endfunction

   function automatic req_type make_pin(logic [1:0] op, logic [5:0] idx);
      req_type q;
      q = '0;
      q.opcode = op; q.entry_index = idx;
      q.dev_major = 4'($urandom); q.dev_minor = 4'($urandom); q.block_number = $urandom;
      return q;
   endfunction

   function automatic req_type make_random();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55)
         return make_get(4'($urandom_range(1)), 4'($urandom_range(1)),
                         hot_blocks[$urandom_range(7)]);
      if (pick < 70) return make_get(4'($urandom), 4'($urandom), $urandom);
      if (pick < 82) return make_pin(OP_PIN, 6'($urandom));
      if (pick < 96) return make_pin(OP_UNPIN, 6'($urandom));
      return make_pin(OP_RSVD, 6'($urandom));
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   initial begin
      for (int i = 0; i < 8; i++) hot_blocks[i] = $urandom;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes, hit at the tail, swap, pins, saturation, reserved opcode
      send_request(make_get(4'hf, 4'hf, 32'hffff_ffff));
      send_request(make_get(4'hf, 4'hf, 32'hffff_ffff));
      send_request(make_get(4'h0, 4'h0, 32'h0));
      send_request(make_get(4'hf, 4'hf, 32'hffff_ffff));
      send_request(make_get(4'h0, 4'h0, 32'h0));
      send_request(make_pin(OP_UNPIN, 6'd0));
      for (int i = 0; i < 17; i++) send_request(make_pin(OP_PIN, 6'd63));
      send_request(make_pin(OP_PIN, 6'd0));
      send_request(make_pin(OP_RSVD, 6'h2a));
      wait_drained();

      // fill every entry, pin them all, then miss: nothing free
      quiet_phase = 1'b1;
      for (int i = 0; i < 64; i++) send_request(make_get(4'h3, 4'h5, 32'(i)));
      for (int i = 0; i < 64; i++) send_request(make_pin(OP_PIN, 6'(i)));
      send_request(make_get(4'h9, 4'h9, 32'h1234));
      for (int i = 0; i < 64; i++) begin
         send_request(make_pin(OP_UNPIN, 6'(i)));
         if (i != 63) send_request(make_pin(OP_UNPIN, 6'(i)));
      end
      quiet_phase = 1'b0;
      wait_drained();

      // long receiver hold-off while requests keep coming
      fork
         begin
            hold_rsp = 1'b1;
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end
         begin
            for (int i = 0; i < 10; i++) send_request(make_random());
            req_valid <= 1'b0;
         end
      join
      wait_drained();

      for (int n = 0; n < 550; n++) begin
         if (n == 300) quiet_phase = 1'b1;
         if (n == 400) quiet_phase = 1'b0;
         if (n % 80 == 79) begin
            hot_blocks[$urandom_range(7)] = $urandom;
            for (int i = 0; i < 6; i++) send_request(make_pin(OP_UNPIN, 6'($urandom)));
         end
         send_request(make_random());
      end

      wait_drained();
      repeat (2000) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
